@@ rtl/core/assert_macros.svh @@
// ============================================================================
// Assertion macros
// Shared helpers for the concurrent checks in the bitmap unit.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock outside reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on the rising clock outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/bbs_pkg.sv @@
// ============================================================================
// Bitmap unit package
// Sizes, operation codes, controller/datapath structs and helper functions.
// ============================================================================
`default_nettype none

package bbs_pkg;

    // Map geometry
    localparam int NBITS     = 1024;
    localparam int WORD_BITS = 32;
    localparam int OFS_W     = $clog2(WORD_BITS);
    localparam int NWORDS    = (NBITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W   = $clog2(NWORDS);

    // Request and response field widths
    localparam int OP_W  = 3;
    localparam int IDX_W = 10;
    localparam int LIM_W = 11;

    // Operation codes; the remaining code does nothing but report the bit.
    typedef enum logic [OP_W-1:0] {
        OP_SET       = 3'd0,
        OP_CLEAR     = 3'd1,
        OP_TEST      = 3'd2,
        OP_TSET      = 3'd3,
        OP_TCLEAR    = 3'd4,
        OP_FIND_ZERO = 3'd5,
        OP_FIND_SET  = 3'd6
    } t_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the request and fetch its first word
        logic advance;  // fetch the next word of a search
        logic finish;   // commit the write-back and load the response
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;     // the current word settles the request
        logic out_free; // the response register can take a new result
    } t_dp_status;

    // Position of the lowest set bit of a word (zero when the word is empty).
    function automatic logic [OFS_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
        logic [OFS_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                pos = OFS_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/bbs_req_if.sv @@
// ============================================================================
// Request channel
// Valid/ready channel that carries one bitmap request.
// ============================================================================
`default_nettype none

interface bbs_req_if
    import bbs_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] bit_index;
    logic [LIM_W-1:0] search_limit;

    modport source (output valid, output op, output bit_index, output search_limit,
                    input ready);
    modport sink   (input valid, input op, input bit_index, input search_limit,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/bbs_rsp_if.sv @@
// ============================================================================
// Response channel
// Valid/ready channel that carries one bitmap response.
// ============================================================================
`default_nettype none

interface bbs_rsp_if
    import bbs_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             old_bit;
    logic             found;
    logic [IDX_W-1:0] found_index;

    modport source (output valid, output old_bit, output found, output found_index,
                    input ready);
    modport sink   (input valid, input old_bit, input found, input found_index,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/bitmap_bit_ops_and_search_unit.sv @@
// ============================================================================
// Bitmap bit operations and search unit
// 1024-bit map with set, clear, test, test-and-modify and bounded searches.
// ============================================================================
//  Channel  Dir  Handshake     Payload
//  i_req    in   valid/ready   op, bit_index, search_limit
//  o_rsp    out  valid/ready   old_bit, found, found_index
//
//  A single-bit request is captured together with its word read, then
//  evaluated and written back. A search visits one 32-bit word per cycle
//  through the store's registered read port. Reset clears the per-word
//  valid bits at once; no clearing pass follows. A stalled response holds
//  the next finished request in evaluation; a new request is taken while a
//  finished response still waits.
// ============================================================================
`default_nettype none

module bitmap_bit_ops_and_search_unit
    import bbs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bbs_req_if.sink   i_req,
    bbs_rsp_if.source o_rsp
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequencing.
    bbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Store, search and response.
    bbs_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_op              (i_req.op),
        .i_bit_index       (i_req.bit_index),
        .i_search_limit    (i_req.search_limit),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_rsp_ready       (o_rsp.ready),
        .o_rsp_valid       (o_rsp.valid),
        .o_rsp_old_bit     (o_rsp.old_bit),
        .o_rsp_found       (o_rsp.found),
        .o_rsp_found_index (o_rsp.found_index)
    );

endmodule

`default_nettype wire

@@ rtl/core/bbs_ctrl.sv @@
// ============================================================================
// Bitmap unit controller
// Sequences request capture, the word-by-word search and the response load.
// ============================================================================
`default_nettype none
`include "assert_macros.svh"

module bbs_ctrl
    import bbs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_req_valid,
    output logic            o_req_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EVAL = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    // Requests are taken only while no request is in progress.
    assign o_req_ready = (r_state == S_IDLE);

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_status.done) begin
                    if (i_status.out_free) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A finished request frees the request side on the next cycle, and an
    // accepted one blocks it until its response has been loaded.
    `ASSERT_NEXT(a_finish_frees, i_clk, i_rst_n, o_cmd.finish, o_req_ready)
    `ASSERT_NEXT(a_load_blocks, i_clk, i_rst_n, o_cmd.load, !o_req_ready)

endmodule

`default_nettype wire

@@ rtl/core/bbs_dpath.sv @@
// ============================================================================
// Bitmap unit datapath
// Word store with per-word valid bits, one-word search stage and response.
// ============================================================================
`default_nettype none
`include "assert_macros.svh"

module bbs_dpath
    import bbs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [OP_W-1:0]  i_op,
    input  wire logic [IDX_W-1:0] i_bit_index,
    input  wire logic [LIM_W-1:0] i_search_limit,
    input  wire t_dp_cmd          i_cmd,
    output t_dp_status            o_status,
    input  wire logic             i_rsp_ready,
    output logic                  o_rsp_valid,
    output logic                  o_rsp_old_bit,
    output logic                  o_rsp_found,
    output logic [IDX_W-1:0]      o_rsp_found_index
);

    // Word store; entries that were never written read as zero.
    logic [WORD_BITS-1:0] mem [NWORDS];
    logic [NWORDS-1:0]    r_wvalid;

    // Captured request.
    logic [OP_W-1:0]      r_op;
    logic [IDX_W-1:0]     r_idx;
    logic [LIM_W-1:0]     r_lim;
    logic [WADDR_W-1:0]   r_word;
    logic                 r_first;
    logic                 r_old;

    // Registered read port.
    logic [WORD_BITS-1:0] r_rd_mem;
    logic                 r_rd_vld;
    logic [WORD_BITS-1:0] rd_data;
    logic [WADDR_W-1:0]   rd_addr;

    // Response register.
    logic                 r_rsp_valid;
    logic                 r_rsp_old;
    logic                 r_rsp_found;
    logic [IDX_W-1:0]     r_rsp_index;

    // Evaluation of the current word.
    t_op                  op;
    logic                 in_map;
    logic                 cur_bit;
    logic                 old_bit;
    logic                 is_find;
    logic                 is_set;
    logic                 is_clr;
    logic [WADDR_W-1:0]   start_word;
    logic [OFS_W-1:0]     start_ofs;
    logic [WADDR_W:0]     lim_word;
    logic [WORD_BITS-1:0] cand;
    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] hi_mask;
    logic [WORD_BITS-1:0] hits;
    logic                 any_hit;
    logic                 more;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] wr_data;
    logic                 wr_en;
    logic [LIM_W-1:0]     lim_eff;

    assign op         = t_op'(r_op);
    assign start_word = WADDR_W'(r_idx >> OFS_W);
    assign start_ofs  = r_idx[OFS_W-1:0];
    assign in_map     = (32'(r_idx) < NBITS);
    assign rd_data    = r_rd_vld ? r_rd_mem : '0;
    assign cur_bit    = in_map ? rd_data[start_ofs] : 1'b0;
    assign old_bit    = r_first ? cur_bit : r_old;

    // The search never looks past the end of the map.
    assign lim_eff  = (32'(i_search_limit) > NBITS) ? LIM_W'(NBITS) : i_search_limit;
    assign lim_word = (WADDR_W + 1)'(r_lim >> OFS_W);

    // Decode the operation.
    always_comb begin
        is_find = 1'b0;
        is_set  = 1'b0;
        is_clr  = 1'b0;
        case (op)
            OP_SET, OP_TSET:         is_set  = 1'b1;
            OP_CLEAR, OP_TCLEAR:     is_clr  = 1'b1;
            OP_FIND_ZERO, OP_FIND_SET: is_find = 1'b1;
            default: begin
            end
        endcase
    end

    // Candidate bits of this word: at or above the start, below the limit.
    always_comb begin
        cand    = (op == OP_FIND_SET) ? rd_data : ~rd_data;
        lo_mask = (r_word == start_word) ? ({WORD_BITS{1'b1}} << start_ofs)
                                         : {WORD_BITS{1'b1}};
        if (lim_word > {1'b0, r_word}) begin
            hi_mask = {WORD_BITS{1'b1}};
        end else if (lim_word == {1'b0, r_word}) begin
            hi_mask = ~({WORD_BITS{1'b1}} << r_lim[OFS_W-1:0]);
        end else begin
            hi_mask = '0;
        end
        hits    = cand & lo_mask & hi_mask;
        any_hit = |hits;
    end

    // Another word is worth fetching only if its first bit lies below the limit.
    assign more = ({(WADDR_W + 1)'(r_word) + 1'b1, {OFS_W{1'b0}}} < r_lim);

    assign o_status.done     = !is_find || any_hit || !more;
    assign o_status.out_free = !r_rsp_valid || i_rsp_ready;

    // Write-back word for single-bit updates.
    assign bit_mask = {{(WORD_BITS - 1){1'b0}}, 1'b1} << start_ofs;
    assign wr_data  = is_set ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
    assign wr_en    = i_cmd.finish && in_map && (is_set || is_clr);

    // First word on capture, the following word while searching.
    assign rd_addr = i_cmd.load ? WADDR_W'(i_bit_index >> OFS_W) : r_word + 1'b1;

    // Word store write and registered read.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_word] <= wr_data;
        end
        if (i_cmd.load || i_cmd.advance) begin
            r_rd_mem <= mem[rd_addr];
        end
    end

    // Per-word valid bits stand in for clearing the store at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid <= '0;
        end else if (wr_en) begin
            r_wvalid[r_word] <= 1'b1;
        end
    end

    // Request capture and search progress.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.advance) begin
            r_rd_vld <= r_wvalid[rd_addr];
            r_word   <= rd_addr;
        end
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_idx   <= i_bit_index;
            r_lim   <= lim_eff;
            r_first <= 1'b1;
        end else if (i_cmd.advance) begin
            r_first <= 1'b0;
        end
        if (i_cmd.advance && r_first) begin
            r_old <= cur_bit;
        end
    end

    // Response register; it holds until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_rsp_old   <= old_bit;
            r_rsp_found <= is_find && any_hit;
            r_rsp_index <= (is_find && any_hit)
                         ? IDX_W'({r_word, lowest_set(hits)}) : '0;
        end
    end

    assign o_rsp_valid       = r_rsp_valid;
    assign o_rsp_old_bit     = r_rsp_old;
    assign o_rsp_found       = r_rsp_found;
    assign o_rsp_found_index = r_rsp_index;

    // A response is never loaded over one that the sink has not taken, and a
    // search only moves on from a word that held no match.
    `ASSERT_IMPLY(a_no_overwrite, i_clk, i_rst_n, i_cmd.finish, !r_rsp_valid || i_rsp_ready)
    `ASSERT_IMPLY(a_advance_miss, i_clk, i_rst_n, i_cmd.advance, is_find && !any_hit && more)
    `ASSERT_NEXT(a_advance_step, i_clk, i_rst_n, i_cmd.advance && !i_cmd.load,
                 r_word == $past(r_word) + 1'b1)

endmodule

`default_nettype wire
